// ===== hdl/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc_pkg
// shared types and codes for the elevator car controller
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CALL  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_OPEN  = 2'd3;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_UP      = 3'd1;
  localparam logic [2:0] MODE_DOWN    = 3'd2;
  localparam logic [2:0] MODE_OPENING = 3'd3;
  localparam logic [2:0] MODE_HELD    = 3'd4;
  localparam logic [2:0] MODE_CLOSING = 3'd5;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] KIND_UP   = 2'd0;
  localparam logic [1:0] KIND_DOWN = 2'd1;
  localparam logic [1:0] KIND_CAR  = 2'd2;

  // scan bounds
  localparam logic [1:0] BND_ANY   = 2'd0;
  localparam logic [1:0] BND_ABOVE = 2'd1;
  localparam logic [1:0] BND_BELOW = 2'd2;

  localparam logic [2:0] REG_POLICY = 3'd0;
  localparam logic [2:0] REG_OPEN   = 3'd1;
  localparam logic [2:0] REG_HOLD   = 3'd2;
  localparam logic [2:0] REG_CLOSE  = 3'd3;
  localparam logic [2:0] REG_RISE   = 3'd4;
  localparam logic [2:0] REG_FALL   = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic       start;      // latch item, run non-selection work
    logic       scan_start; // clear scan best, begin pass
    logic [2:0] kinds;      // kind mask for pass
    logic [1:0] bound;
    logic       want_high;
    logic       scan_step;  // examine one entry
    logic       shift_step; // move one entry down
    logic       commit;     // remove chosen, set target
    logic       use_first;  // pick entry 0
    logic       empty_sel;  // selection with empty table
  } ecc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sel;   // item requires selection
    logic sweep;      // scan policy applies
    logic dir_up;
    logic scan_last;  // scan index at last entry
    logic found;
    logic shift_done;
  } ecc_sts_t;

endpackage

// ===== hdl/ecc_datapath.sv =====
// ----------------------------------------------------------------------------
// ecc_datapath
// call table, timers, car state and the serial call scanner
// ----------------------------------------------------------------------------
module ecc_datapath #(
  parameter int FLOORS = 16,
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ecc_pkg::ecc_cmd_t     cmd,
  output ecc_pkg::ecc_sts_t     sts,
  input  logic [1:0]            operation,
  input  logic [1:0]            call_kind,
  input  logic [3:0]            call_floor,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output logic [3:0]            car_floor,
  output logic [3:0]            target_floor,
  output logic [2:0]            car_mode,
  output logic [4:0]            pending_calls,
  output logic                  call_dropped
);
  import ecc_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int FW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int EW = 2 + FW;

  logic       policy;
  logic [7:0] open_time, hold_time, close_time, rise_time, fall_time;
  logic [2:0] mode;
  logic [1:0] dir;
  logic [FW-1:0] floor_now, floor_goal;
  logic [7:0] door_ticks, travel_ticks;
  logic [CW-1:0] count;
  logic       dropped;
  logic       need_q;
  logic [EW-1:0] mem [TABLE_DEPTH];

  logic [IW-1:0] idx, best;
  logic [FW-1:0] best_f;
  logic          found;
  logic [2:0]    kinds_q;
  logic [1:0]    bound_q;
  logic          high_q;

  // read port: scan or shift
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  assign rd_addr = cmd.shift_step ? IW'(idx + 1'b1) : idx;
  always_ff @(posedge clk) rd_data <= mem[rd_addr];

  logic [1:0]    ent_kind;
  logic [FW-1:0] ent_floor;
  assign ent_kind  = rd_data[EW-1 -: 2];
  assign ent_floor = rd_data[FW-1:0];

  // read data is registered, so it lags idx: track the examined index
  logic [IW-1:0] seen;
  logic          seen_ok;
  logic          shift_ok;

  logic [7:0] door_inc, trav_inc;
  assign door_inc = (door_ticks == 8'hff) ? 8'hff : door_ticks + 8'd1;
  assign trav_inc = (travel_ticks == 8'hff) ? 8'hff : travel_ticks + 8'd1;

  function automatic logic [7:0] restart(input logic [7:0] span, input logic [7:0] now);
    logic [9:0] s;
    s = {2'b0, span} - {2'b0, now} - 10'd2;
    return s[9] ? 8'd0 : s[7:0];
  endfunction

  logic ent_ok;
  always_comb begin
    ent_ok = kinds_q[ent_kind] && (ent_kind != 2'd3);
    if (bound_q == BND_ABOVE && ent_floor < floor_now) ent_ok = 1'b0;
    if (bound_q == BND_BELOW && ent_floor > floor_now) ent_ok = 1'b0;
  end

  // status
  always_comb begin
    sts.need_sel   = need_q;
    sts.sweep      = !policy && dir != DIR_NONE;
    sts.dir_up     = dir == DIR_UP;
    sts.scan_last  = CW'(idx) + 1'b1 >= count;
    sts.found      = found;
    sts.shift_done = CW'(idx) >= count;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
      open_time <= 8'd4; hold_time <= 8'd4; close_time <= 8'd4;
      rise_time <= 8'd4; fall_time <= 8'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POLICY: policy <= cfg_data[0];
        REG_OPEN:   open_time <= cfg_data;
        REG_HOLD:   hold_time <= cfg_data;
        REG_CLOSE:  close_time <= cfg_data;
        REG_RISE:   rise_time <= cfg_data;
        REG_FALL:   fall_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // table write port
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  always_comb begin
    wr_en = 1'b0; wr_addr = idx; wr_data = rd_data;
    if (cmd.start && operation == OP_CALL && call_kind != 2'd3 &&
        32'(call_floor) < FLOORS && count < CW'(TABLE_DEPTH)) begin
      wr_en = 1'b1;
      wr_addr = count[IW-1:0];
      wr_data = {call_kind, FW'(call_floor)};
    end else if (shift_ok) begin
      wr_en = 1'b1;
      wr_addr = seen;
    end
  end
  always_ff @(posedge clk) if (wr_en) mem[wr_addr] <= wr_data;

  // main state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE; dir <= DIR_NONE;
      floor_now <= '0; floor_goal <= '0;
      door_ticks <= '0; travel_ticks <= '0;
      count <= '0; dropped <= 1'b0; need_q <= 1'b0;
      idx <= '0; best <= '0; best_f <= '0; found <= 1'b0;
      seen <= '0; seen_ok <= 1'b0; shift_ok <= 1'b0;
      kinds_q <= '0; bound_q <= BND_ANY; high_q <= 1'b0;
    end else begin
      seen_ok <= 1'b0;
      shift_ok <= 1'b0;
      if (cmd.start) begin
        // selection decided from the state before this item
        need_q <= (operation == OP_TICK) &&
                  (mode == MODE_IDLE || (mode == MODE_CLOSING && door_inc >= close_time));
        dropped <= 1'b0;
        idx <= '0;
        unique case (operation)
          OP_TICK: begin
            unique case (mode)
              MODE_OPENING: if (door_inc >= open_time) begin
                door_ticks <= '0; mode <= MODE_HELD;
              end else door_ticks <= door_inc;
              MODE_HELD: if (door_inc >= hold_time) begin
                door_ticks <= '0; mode <= MODE_CLOSING;
              end else door_ticks <= door_inc;
              MODE_CLOSING: door_ticks <= door_inc;
              MODE_UP, MODE_DOWN: begin
                if (trav_inc >= ((mode == MODE_UP) ? rise_time : fall_time)) begin
                  logic [FW-1:0] nf;
                  nf = floor_now;
                  if (mode == MODE_UP && 32'(floor_now) + 1 < FLOORS) nf = floor_now + 1'b1;
                  if (mode == MODE_DOWN && floor_now != '0) nf = floor_now - 1'b1;
                  floor_now <= nf;
                  travel_ticks <= '0;
                  if (nf == floor_goal) begin
                    mode <= MODE_OPENING; door_ticks <= '0;
                  end
                end else travel_ticks <= trav_inc;
              end
              MODE_IDLE: ;
              default: mode <= MODE_IDLE;
            endcase
          end
          OP_CALL: if (call_kind != 2'd3 && 32'(call_floor) < FLOORS) begin
            if (count >= CW'(TABLE_DEPTH)) dropped <= 1'b1;
            else count <= count + 1'b1;
          end
          OP_CLOSE: begin
            if (mode == MODE_OPENING) begin
              mode <= MODE_CLOSING; door_ticks <= restart(close_time, door_ticks);
            end else if (mode == MODE_HELD) begin
              mode <= MODE_CLOSING; door_ticks <= '0;
            end
          end
          default: begin
            if (mode == MODE_IDLE) begin
              mode <= MODE_OPENING; door_ticks <= '0;
            end else if (mode == MODE_CLOSING) begin
              mode <= MODE_OPENING; door_ticks <= restart(open_time, door_ticks);
            end
          end
        endcase
      end
      // scanning: idx issues reads, seen follows in the next cycle
      if (cmd.scan_start) begin
        idx <= '0; found <= 1'b0;
        kinds_q <= cmd.kinds; bound_q <= cmd.bound; high_q <= cmd.want_high;
      end
      if (cmd.scan_step) begin
        if (!sts.scan_last) idx <= idx + 1'b1;
        seen <= idx; seen_ok <= 1'b1;
      end
      if (seen_ok && ent_ok &&
          (!found || (high_q ? ent_floor > best_f : ent_floor < best_f))) begin
        found <= 1'b1; best <= seen; best_f <= ent_floor;
      end
      // commit: chosen entry known, start shifting from it
      if (cmd.commit) begin
        logic [FW-1:0] g;
        logic [IW-1:0] b;
        b = (cmd.use_first || !found) ? '0 : best;
        g = (cmd.use_first || !found) ? ent_floor : best_f;
        idx <= b;
        count <= count - 1'b1;
        floor_goal <= g;
        if (g > floor_now) begin
          travel_ticks <= '0; mode <= MODE_UP; dir <= DIR_UP;
        end else if (g < floor_now) begin
          travel_ticks <= '0; mode <= MODE_DOWN; dir <= DIR_DOWN;
        end else begin
          mode <= MODE_OPENING; door_ticks <= '0;
        end
      end
      // shift: read idx+1 now, write it to idx next cycle
      if (cmd.shift_step) begin
        seen <= idx; shift_ok <= 1'b1;
        idx <= idx + 1'b1;
      end
      if (cmd.empty_sel && mode == MODE_CLOSING) mode <= MODE_IDLE;
    end
  end

  // entry 0 floor for first-come pick is the registered read of idx 0
  assign car_floor     = 4'(floor_now);
  assign target_floor  = 4'(floor_goal);
  assign car_mode      = mode;
  assign pending_calls = 5'(count);
  assign call_dropped  = dropped;

endmodule

// ===== hdl/ecc_control.sv =====
// ----------------------------------------------------------------------------
// ecc_control
// sequencer for item handling, table scans, removal and result handoff
// ----------------------------------------------------------------------------
module ecc_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_ready,
  input  logic              empty,
  input  ecc_pkg::ecc_sts_t sts,
  output ecc_pkg::ecc_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid
);
  import ecc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_PASS  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_FIRST = 4'd5;
  localparam logic [3:0] S_FWAIT = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_SWAIT = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_LAND  = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pass <= '0;
    end else begin
      state <= state_next; pass <= pass_next;
    end
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_DONE;

  // sequencing
  always_comb begin
    cmd = '0;
    state_next = state;
    pass_next = pass;
    cmd.start = in_fire;
    // pass descriptors
    unique case ({sts.dir_up, pass})
      {1'b1, 2'd0}: begin cmd.kinds = 3'b101; cmd.bound = BND_ABOVE; cmd.want_high = 1'b0; end
      {1'b1, 2'd1}: begin cmd.kinds = 3'b110; cmd.bound = BND_ANY;   cmd.want_high = 1'b1; end
      {1'b1, 2'd2}: begin cmd.kinds = 3'b001; cmd.bound = BND_ANY;   cmd.want_high = 1'b0; end
      {1'b0, 2'd0}: begin cmd.kinds = 3'b110; cmd.bound = BND_BELOW; cmd.want_high = 1'b1; end
      {1'b0, 2'd1}: begin cmd.kinds = 3'b101; cmd.bound = BND_ANY;   cmd.want_high = 1'b0; end
      {1'b0, 2'd2}: begin cmd.kinds = 3'b010; cmd.bound = BND_ANY;   cmd.want_high = 1'b1; end
      default: ;
    endcase
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_CHECK;
      S_CHECK: begin
        if (!sts.need_sel) state_next = S_DONE;
        else if (empty) begin
          cmd.empty_sel = 1'b1; state_next = S_DONE;
        end else if (sts.sweep) begin
          pass_next = '0; state_next = S_PASS;
        end else state_next = S_FIRST;
      end
      S_PASS: begin
        cmd.scan_start = 1'b1; state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_LAND;
      end
      // last entry read is compared before the pass is judged
      S_LAND: state_next = S_DRAIN;
      S_DRAIN: begin
        if (sts.found || pass == 2'd2) begin
          cmd.commit = 1'b1; state_next = S_SHIFT;
        end else begin
          pass_next = pass + 2'd1; state_next = S_PASS;
        end
      end
      // entry 0 read is registered and used in S_FWAIT
      S_FIRST: begin
        cmd.scan_start = 1'b1; state_next = S_FWAIT;
      end
      S_FWAIT: begin
        cmd.commit = 1'b1; cmd.use_first = 1'b1; state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_next = S_SWAIT;
        else cmd.shift_step = 1'b1;
      end
      S_SWAIT: state_next = S_DONE;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> state == S_SHIFT);
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("overlap");

endmodule

// ===== hdl/elevator_car_controller.sv =====
// ----------------------------------------------------------------------------
// elevator_car_controller
// single car controller with call table and sweep or arrival-order policy
// ----------------------------------------------------------------------------
// Input items (operation, call_kind, call_floor) transfer on in_valid and
// in_ready; one result (car_floor, target_floor, car_mode, pending_calls,
// call_dropped) transfers on out_valid and out_ready per item.
// Configuration writes (cfg_index, cfg_data) transfer on cfg_valid/cfg_ready
// and are always taken; write only between items.
// One item at a time: a new item is taken only after the last result has
// transferred. A call selection walks the call table serially with one read
// port, in up to three scan passes followed by a shift that removes the
// chosen call from the table.
// The result is held while out_ready is low and no new item is taken.
// Reset (rst, synchronous) puts the car idle at floor 0 with an empty
// table and default times of 4 ticks.
// ----------------------------------------------------------------------------
module elevator_car_controller #(
  parameter int FLOORS = 16,
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [1:0] call_kind,
  input  logic [3:0] call_floor,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] car_floor,
  output logic [3:0] target_floor,
  output logic [2:0] car_mode,
  output logic [4:0] pending_calls,
  output logic       call_dropped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import ecc_pkg::*;

  ecc_cmd_t cmd;
  ecc_sts_t sts;

  assign cfg_ready = 1'b1;

  ecc_control u_ctl (
    .clk, .rst,
    .in_fire (in_valid && in_ready),
    .out_ready,
    .empty (pending_calls == 5'd0),
    .sts, .cmd, .in_ready, .out_valid
  );

  ecc_datapath #(.FLOORS(FLOORS), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .operation, .call_kind, .call_floor,
    .cfg_valid, .cfg_index, .cfg_data,
    .car_floor, .target_floor, .car_mode, .pending_calls, .call_dropped
  );

endmodule

// ===== verif/tb_elevator_car_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_elevator_car_controller
// directed and random checks of the elevator car controller: a local model
// of the car and its call table predicts every result, which is compared
// field by field as results transfer out
// ----------------------------------------------------------------------------
module tb_elevator_car_controller;
  import ecc_pkg::*;

  localparam int NFLOORS = 16;
  localparam int NDEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  logic [1:0] call_kind;
  logic [3:0] call_floor;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] car_floor;
  logic [3:0] target_floor;
  logic [2:0] car_mode;
  logic [4:0] pending_calls;
  logic       call_dropped;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  typedef struct packed {
    logic [3:0] flr;
    logic [3:0] goal;
    logic [2:0] mode;
    logic [4:0] pending;
    logic       dropped;
  } car_status_t;

  car_status_t status_q[$];
  int          err_count;
  int          cycle_count;
  int          out_stall_max;

  // model state
  logic       m_policy;
  int         m_open, m_hold, m_close, m_rise, m_fall;
  logic [2:0] m_mode;
  logic [1:0] m_dir;
  int         m_floor, m_goal, m_door, m_travel, m_count;
  logic [1:0] m_kind[NDEPTH];
  int         m_cfloor[NDEPTH];

  elevator_car_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .call_kind(call_kind), .call_floor(call_floor),
    .out_valid(out_valid), .out_ready(out_ready),
    .car_floor(car_floor), .target_floor(target_floor), .car_mode(car_mode),
    .pending_calls(pending_calls), .call_dropped(call_dropped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic int restart_ticks(input int span, input int now);
    if (span < now + 2) return 0;
    return span - now - 2;
  endfunction

  function automatic int bump(input int v);
    return (v >= 255) ? 255 : v + 1;
  endfunction

  // bound 0 any, 1 at or above car, 2 at or below car
  function automatic int scan_calls(input logic [2:0] kinds, input logic [1:0] bnd,
                                    input bit want_high);
    int best;
    int bf;
    best = -1;
    bf = 0;
    for (int i = 0; i < m_count; i++) begin
      if (!kinds[m_kind[i]]) continue;
      if (bnd == BND_ABOVE && m_cfloor[i] < m_floor) continue;
      if (bnd == BND_BELOW && m_cfloor[i] > m_floor) continue;
      if (best < 0 || (want_high ? m_cfloor[i] > bf : m_cfloor[i] < bf)) begin
        best = i;
        bf = m_cfloor[i];
      end
    end
    return best;
  endfunction

  task automatic pick_next_call();
    int idx;
    logic [2:0] up_set;
    logic [2:0] dn_set;
    up_set = 3'b101;
    dn_set = 3'b110;
    if (m_count == 0) begin
      if (m_mode == MODE_CLOSING) m_mode = MODE_IDLE;
      return;
    end
    if (m_policy || m_dir == DIR_NONE) begin
      idx = 0;
    end else if (m_dir == DIR_UP) begin
      idx = scan_calls(up_set, BND_ABOVE, 1'b0);
      if (idx < 0) idx = scan_calls(dn_set, BND_ANY, 1'b1);
      if (idx < 0) idx = scan_calls(3'b001, BND_ANY, 1'b0);
    end else begin
      idx = scan_calls(dn_set, BND_BELOW, 1'b1);
      if (idx < 0) idx = scan_calls(up_set, BND_ANY, 1'b0);
      if (idx < 0) idx = scan_calls(3'b010, BND_ANY, 1'b1);
    end
    if (idx < 0) idx = 0;
    m_goal = m_cfloor[idx];
    for (int i = idx; i + 1 < m_count; i++) begin
      m_kind[i] = m_kind[i + 1];
      m_cfloor[i] = m_cfloor[i + 1];
    end
    m_count--;
    if (m_goal > m_floor) begin
      m_travel = 0;
      m_mode = MODE_UP;
      m_dir = DIR_UP;
    end else if (m_goal < m_floor) begin
      m_travel = 0;
      m_mode = MODE_DOWN;
      m_dir = DIR_DOWN;
    end else begin
      m_mode = MODE_OPENING;
      m_door = 0;
    end
  endtask

  task automatic advance_tick();
    case (m_mode)
      MODE_IDLE: pick_next_call();
      MODE_OPENING: begin
        m_door = bump(m_door);
        if (m_door >= m_open) begin
          m_door = 0;
          m_mode = MODE_HELD;
        end
      end
      MODE_HELD: begin
        m_door = bump(m_door);
        if (m_door >= m_hold) begin
          m_door = 0;
          m_mode = MODE_CLOSING;
        end
      end
      MODE_CLOSING: begin
        m_door = bump(m_door);
        if (m_door >= m_close) pick_next_call();
      end
      MODE_UP: begin
        m_travel = bump(m_travel);
        if (m_travel >= m_rise) begin
          if (m_floor + 1 < NFLOORS) m_floor++;
          m_travel = 0;
          if (m_floor == m_goal) begin
            m_mode = MODE_OPENING;
            m_door = 0;
          end
        end
      end
      MODE_DOWN: begin
        m_travel = bump(m_travel);
        if (m_travel >= m_fall) begin
          if (m_floor > 0) m_floor--;
          m_travel = 0;
          if (m_floor == m_goal) begin
            m_mode = MODE_OPENING;
            m_door = 0;
          end
        end
      end
      default: m_mode = MODE_IDLE;
    endcase
  endtask

  // predict the result of one item and queue it
  task automatic predict_status(input logic [1:0] op, input logic [1:0] kind,
                                input logic [3:0] flr);
    car_status_t s;
    logic dropped;
    dropped = 1'b0;
    case (op)
      OP_TICK: advance_tick();
      OP_CALL: begin
        if (kind <= KIND_CAR && int'(flr) < NFLOORS) begin
          if (m_count >= NDEPTH) begin
            dropped = 1'b1;
          end else begin
            m_kind[m_count] = kind;
            m_cfloor[m_count] = flr;
            m_count++;
          end
        end
      end
      OP_CLOSE: begin
        if (m_mode == MODE_OPENING) begin
          m_mode = MODE_CLOSING;
          m_door = restart_ticks(m_close, m_door);
        end else if (m_mode == MODE_HELD) begin
          m_mode = MODE_CLOSING;
          m_door = 0;
        end
      end
      default: begin
        if (m_mode == MODE_IDLE) begin
          m_mode = MODE_OPENING;
          m_door = 0;
        end else if (m_mode == MODE_CLOSING) begin
          m_mode = MODE_OPENING;
          m_door = restart_ticks(m_open, m_door);
        end
      end
    endcase
    s.flr = m_floor[3:0];
    s.goal = m_goal[3:0];
    s.mode = m_mode;
    s.pending = m_count[4:0];
    s.dropped = dropped;
    status_q.push_back(s);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // send one item, predicting its result at the transfer
  task automatic send_item(input logic [1:0] op, input logic [1:0] kind,
                           input logic [3:0] flr);
    int g;
    g = gap_len();
    // always move to a fresh falling edge so valid is never driven twice at once
    repeat (g + 1) @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    call_kind <= kind;
    call_floor <= flr;
    do @(posedge clk); while (!in_ready);
    predict_status(op, kind, flr);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POLICY: m_policy = val[0];
      REG_OPEN:   m_open = val;
      REG_HOLD:   m_hold = val;
      REG_CLOSE:  m_close = val;
      REG_RISE:   m_rise = val;
      REG_FALL:   m_fall = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (status_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_times(input logic pol, input logic [7:0] op_t, input logic [7:0] ho,
                           input logic [7:0] cl, input logic [7:0] ri, input logic [7:0] fa);
    wait_idle();
    write_reg(REG_POLICY, {7'd0, pol});
    write_reg(REG_OPEN, op_t);
    write_reg(REG_HOLD, ho);
    write_reg(REG_CLOSE, cl);
    write_reg(REG_RISE, ri);
    write_reg(REG_FALL, fa);
  endtask

  // result checker
  always @(posedge clk) begin
    car_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $display("result with nothing expected");
        err_count++;
      end else begin
        want = status_q.pop_front();
        if (car_floor !== want.flr) report_error("car_floor", car_floor, want.flr);
        if (target_floor !== want.goal) report_error("target_floor", target_floor, want.goal);
        if (car_mode !== want.mode) report_error("car_mode", car_mode, want.mode);
        if (pending_calls !== want.pending)
          report_error("pending_calls", pending_calls, want.pending);
        if (call_dropped !== want.dropped)
          report_error("call_dropped", call_dropped, want.dropped);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (out_stall_max == 0) out_ready <= 1'b1;
    else if (r < 60) out_ready <= 1'b1;
    else if (r < 95) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, out_stall_max) == 0);
  end

  // directed: field extremes, every operation, button corner cases, table full
  task automatic test_directed();
    send_item(OP_OPEN, 2'd0, 4'd0);
    send_item(OP_CLOSE, 2'd0, 4'd0);
    send_item(OP_OPEN, 2'd0, 4'd0);
    send_item(OP_TICK, 2'd0, 4'd0);
    send_item(OP_TICK, 2'd0, 4'd0);
    send_item(OP_TICK, 2'd0, 4'd0);
    send_item(OP_CLOSE, 2'd0, 4'd0);
    send_item(OP_OPEN, 2'd0, 4'd0);
    send_item(OP_CALL, 2'd3, 4'd15);
    for (int i = 0; i < 17; i++)
      send_item(OP_CALL, 2'(i % 3), 4'(15 - i));
    repeat (4) send_item(OP_TICK, 2'd0, 4'd0);
  endtask

  // random mix, mostly ticks so calls get served
  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_item(OP_TICK, 2'($urandom), 4'($urandom));
      else if (r < 88) send_item(OP_CALL, 2'($urandom_range(0, 3)), 4'($urandom));
      else if (r < 94) send_item(OP_CLOSE, 2'($urandom), 4'($urandom));
      else send_item(OP_OPEN, 2'($urandom), 4'($urandom));
    end
  endtask

  task automatic test_sweep_fast();
    set_times(1'b0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    test_random(350);
  endtask

  task automatic test_fcfs_default();
    set_times(1'b1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4);
    test_random(350);
  endtask

  task automatic test_long_times();
    set_times(1'b0, 8'd255, 8'd3, 8'd255, 8'd2, 8'd3);
    test_random(250);
  endtask

  task automatic test_mixed();
    out_stall_max = 40;
    set_times(1'b1, 8'd2, 8'd1, 8'd5, 8'd3, 8'd1);
    test_random(300);
    set_times(1'b0, 8'd6, 8'd2, 8'd3, 8'd1, 8'd255);
    test_random(350);
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    out_stall_max = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_TICK;
    call_kind = KIND_UP;
    call_floor = 4'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_POLICY;
    cfg_data = 8'd0;
    out_ready = 1'b1;
    m_policy = 1'b0;
    m_open = 4; m_hold = 4; m_close = 4; m_rise = 4; m_fall = 4;
    m_mode = MODE_IDLE;
    m_dir = DIR_NONE;
    m_floor = 0; m_goal = 0; m_door = 0; m_travel = 0; m_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_sweep_fast();
    test_fcfs_default();
    test_long_times();
    test_mixed();
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
